>>> rtl/core/table_linear_interpolator_unit_assert.svh
// Assertion macros for the table linear interpolator.
// TLI_ASSERT_IMP checks a same-cycle implication, TLI_ASSERT_NXT one that
// holds in the following cycle. Both are disabled while reset is asserted.
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define TLI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TLI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TLI_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define TLI_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/tli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = 2 * DATA_W;
    localparam int IDX_W      = 6;
    localparam int PIU_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_IDX   = 2'd1;

    localparam logic [PIU_W-1:0] PIU_RESET = 7'd2;

    localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXACT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic query_start;
        logic scan_step;
        logic calc;
        logic mul;
        logic div_step;
        logic out_load;
    } t_tli_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_done;
        logic match;
        logic have_lo;
        logic have_hi;
        logic div_last;
        logic out_free;
    } t_tli_sts;

endpackage

`default_nettype wire

>>> rtl/core/tli_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tli_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_opcode,
    output logic                   o_in_stall,
    input  wire tli_pkg::t_tli_sts i_sts,
    output tli_pkg::t_tli_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state;
    t_state            n_state;
    tli_pkg::t_tli_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == tli_pkg::OP_LOAD) begin
                        cmd.load_we = 1'b1;
                    end else begin
                        cmd.query_start = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    // An exact hit or a query outside the table skips the divide.
                    if (i_sts.match || !i_sts.have_lo || !i_sts.have_hi) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> rtl/core/tli_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tli_datapath #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tli_pkg::t_tli_cmd                   i_cmd,
    output tli_pkg::t_tli_sts                        o_sts,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]     i_points,
    input  wire logic                                i_mode,
    input  wire logic [tli_pkg::IDX_W-1:0]           i_entry_index,
    input  wire logic [tli_pkg::DATA_W-1:0]          i_point_x,
    input  wire logic [tli_pkg::DATA_W-1:0]          i_point_y,
    input  wire logic [tli_pkg::DATA_W-1:0]          i_query_x,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output logic [tli_pkg::DATA_W-1:0]               o_result_y,
    output logic [tli_pkg::STATUS_W-1:0]             o_status
);

    localparam int DW = tli_pkg::DATA_W;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Table memory: x in the upper half of each word, y in the lower half.
    logic                       ram_we;
    logic [tli_pkg::ENTRY_W-1:0] ram_rdata;
    logic signed [DW-1:0]       rd_x;
    logic signed [DW-1:0]       rd_y;

    logic [CW-1:0]        r_cnt;
    logic                 r_rd_vld;
    logic signed [DW-1:0] r_q;
    logic                 r_match;
    logic signed [DW-1:0] r_ym;
    logic                 r_lo;
    logic signed [DW-1:0] r_x1;
    logic signed [DW-1:0] r_y1;
    logic                 r_hi;
    logic signed [DW-1:0] r_x2;
    logic signed [DW-1:0] r_y2;

    logic [DW:0]          dy_wide;
    logic [DW:0]          dv_wide;
    logic [DW:0]          dx_wide;
    logic [DW:0]          dy_mag;
    logic                 r_dy_neg;
    logic [DW-1:0]        r_dy_mag;
    logic [DW-1:0]        r_dv;
    logic [DW-1:0]        r_dx;

    logic [2*DW-1:0]      product;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_qr;
    logic [tli_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DW:0]          div_trial;
    logic [DW:0]          div_diff;

    logic signed [DW+1:0] res_wide;
    logic [DW-1:0]        res_sat;
    logic [DW-1:0]        fin_y;
    logic [tli_pkg::STATUS_W-1:0] fin_status;

    logic                 r_out_valid;
    logic [DW-1:0]        r_out_y;
    logic [tli_pkg::STATUS_W-1:0] r_out_status;
    logic                 out_free;

    assign ram_we = i_cmd.load_we && (int'(i_entry_index) < MAX_POINTS);

    tli_ram #(
        .WIDTH (tli_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[tli_pkg::ENTRY_W-1:DW];
    assign rd_y = ram_rdata[DW-1:0];

    // Scan: one table read issued per cycle, evaluated in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_match  <= 1'b0;
            r_lo     <= 1'b0;
            r_hi     <= 1'b0;
        end else if (i_cmd.query_start) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_match  <= 1'b0;
            r_lo     <= 1'b0;
            r_hi     <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_cnt != i_points) begin
                r_cnt    <= r_cnt + CW'(1);
                r_rd_vld <= 1'b1;
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (r_rd_vld) begin
                if (!r_match && (rd_x == r_q)) begin
                    r_match <= 1'b1;
                end
                if ((rd_x < r_q) && (!r_lo || (rd_x > r_x1))) begin
                    r_lo <= 1'b1;
                end
                if ((rd_x > r_q) && (!r_hi || (rd_x < r_x2))) begin
                    r_hi <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_q <= i_query_x;
        end
        if (i_cmd.scan_step && r_rd_vld) begin
            if (!r_match && (rd_x == r_q)) begin
                r_ym <= rd_y;
            end
            if ((rd_x < r_q) && (!r_lo || (rd_x > r_x1))) begin
                r_x1 <= rd_x;
                r_y1 <= rd_y;
            end
            if ((rd_x > r_q) && (!r_hi || (rd_x < r_x2))) begin
                r_x2 <= rd_x;
                r_y2 <= rd_y;
            end
        end
    end

    // Differences. The x differences are positive since x1 < q < x2.
    assign dy_wide = {r_y2[DW-1], r_y2} - {r_y1[DW-1], r_y1};
    assign dv_wide = {r_q[DW-1], r_q} - {r_x1[DW-1], r_x1};
    assign dx_wide = {r_x2[DW-1], r_x2} - {r_x1[DW-1], r_x1};
    assign dy_mag  = dy_wide[DW] ? (~dy_wide + (DW+1)'(1)) : dy_wide;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_dy_neg <= dy_wide[DW];
            r_dy_mag <= dy_mag[DW-1:0];
            r_dv     <= dv_wide[DW-1:0];
            r_dx     <= dx_wide[DW-1:0];
        end
    end

    // Restoring divider. The quotient is below |dy|, so the upper half of the
    // product is already below the divisor and 32 steps suffice.
    assign product   = r_dy_mag * r_dv;
    assign div_trial = {r_rem, r_qr[DW-1]};
    assign div_diff  = div_trial - {1'b0, r_dx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem     <= product[2*DW-1:DW];
            r_qr      <= product[DW-1:0];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!div_diff[DW]) begin
                r_rem <= div_diff[DW-1:0];
                r_qr  <= {r_qr[DW-2:0], 1'b1};
            end else begin
                r_rem <= div_trial[DW-1:0];
                r_qr  <= {r_qr[DW-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + tli_pkg::DIV_CNT_W'(1);
        end
    end

    assign res_wide = r_dy_neg
        ? ($signed({{2{r_y1[DW-1]}}, r_y1}) - $signed({2'b00, r_qr}))
        : ($signed({{2{r_y1[DW-1]}}, r_y1}) + $signed({2'b00, r_qr}));

    always_comb begin
        if (res_wide > $signed({3'b000, {(DW-1){1'b1}}})) begin
            res_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (res_wide < $signed({3'b111, {(DW-1){1'b0}}})) begin
            res_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            res_sat = res_wide[DW-1:0];
        end
    end

    always_comb begin
        if (r_match) begin
            fin_y      = r_ym;
            fin_status = tli_pkg::ST_EXACT;
        end else if (!r_lo) begin
            fin_y      = '0;
            fin_status = i_mode ? tli_pkg::ST_BELOW : tli_pkg::ST_INTERP;
        end else if (!r_hi) begin
            fin_y      = '0;
            fin_status = i_mode ? tli_pkg::ST_ABOVE : tli_pkg::ST_INTERP;
        end else begin
            fin_y      = res_sat;
            fin_status = tli_pkg::ST_INTERP;
        end
    end

    // Output register; it frees up in the same cycle its item is taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_y      <= fin_y;
            r_out_status <= fin_status;
        end
    end

    assign o_sts.scan_done = (r_cnt == i_points) && !r_rd_vld;
    assign o_sts.match     = r_match;
    assign o_sts.have_lo   = r_lo;
    assign o_sts.have_hi   = r_hi;
    assign o_sts.div_last  = (r_div_cnt == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1));
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_result_y  = r_out_y;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

>>> rtl/core/table_linear_interpolator_unit.sv
// Piecewise linear interpolator over a table of signed Q16.16 (x, y) points.
// Input channel (i_in_valid / o_in_stall): an item with opcode load writes
// point_x and point_y into slot entry_index; an item with opcode query asks
// for the value at query_x. Output channel (o_out_valid / i_out_stall): one
// item per query with result_y and status, none per load.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
// sets points_in_use, index 1 sets out_of_range_mode. Write only while idle.
// A query scans n = min(points_in_use, MAX_POINTS) slots through the single
// table read port, one per cycle. An exact match or an out-of-table query then
// goes straight to the final state. An interpolation adds a differences step,
// the 32x32 multiply and the restoring divider before the final state.
// One query is in flight at a time; the input stalls until its result is
// loaded and takes the next item in the following cycle.
// Synchronous reset clears the controller, the output register and the
// configuration (points_in_use = 2, mode 0); table contents are undefined
// until written. A finished result sits in the output register while the
// receiver stalls, and the next item is accepted meanwhile; a later query
// waits in its final state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "table_linear_interpolator_unit_assert.svh"

module table_linear_interpolator_unit #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_opcode,
    input  wire logic [tli_pkg::IDX_W-1:0]         i_entry_index,
    input  wire logic [tli_pkg::DATA_W-1:0]        i_point_x,
    input  wire logic [tli_pkg::DATA_W-1:0]        i_point_y,
    input  wire logic [tli_pkg::DATA_W-1:0]        i_query_x,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [tli_pkg::DATA_W-1:0]             o_result_y,
    output logic [tli_pkg::STATUS_W-1:0]           o_status,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tli_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tli_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [tli_pkg::PIU_W-1:0] r_points_in_use;
    logic                      r_mode;
    logic [CW-1:0]             points_eff;
    logic                      cfg_we;

    tli_pkg::t_tli_cmd cmd;
    tli_pkg::t_tli_sts sts;

    // Configuration registers. Writes to indexes past the list are ignored.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= tli_pkg::PIU_RESET;
            r_mode          <= 1'b0;
        end else if (cfg_we) begin
            if (i_cfg_index == tli_pkg::CFG_POINTS_IDX) begin
                r_points_in_use <= i_cfg_data[tli_pkg::PIU_W-1:0];
            end else if (i_cfg_index == tli_pkg::CFG_MODE_IDX) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    // The scan never runs past the physical table.
    always_comb begin
        if (int'(r_points_in_use) > MAX_POINTS) begin
            points_eff = CW'(MAX_POINTS);
        end else begin
            points_eff = CW'(r_points_in_use);
        end
    end

    tli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tli_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_points      (points_eff),
        .i_mode        (r_mode),
        .i_entry_index (i_entry_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_query_x     (i_query_x),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_y    (o_result_y),
        .o_status      (o_status)
    );

    // A query keeps the input stalled in the cycle after it is accepted.
    `TLI_ASSERT_NXT(a_query_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_opcode == tli_pkg::OP_QUERY), o_in_stall)

    // A result is only loaded when the output register can take it.
    `TLI_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, cmd.out_load, sts.out_free)

    // Table writes never overlap a scan of the table.
    `TLI_ASSERT_IMP(a_load_not_scan, i_clk, i_rst_n, cmd.load_we, !cmd.scan_step)

    // The divider only runs once the scan has completed.
    `TLI_ASSERT_IMP(a_div_after_scan, i_clk, i_rst_n, cmd.div_step, sts.scan_done)

endmodule

`default_nettype wire
